[rtl/core/apcpi_pkg.sv]
// ----------------------------------------------------------------------------
// apcpi_pkg
// Shared types, register codes, reset values and the microcode program of
// the cascaded altitude/pitch PI controller.
// ----------------------------------------------------------------------------
package apcpi_pkg;

  // fixed formats
  localparam int unsigned SigW   = 32;            // Q16.16 signal
  localparam int unsigned GainW  = 32;            // Q8.24 gain
  localparam int unsigned ErrW   = SigW + 1;      // error, one guard bit
  localparam int unsigned IntW   = 48;            // integrator
  localparam int unsigned HalfW  = IntW / 2;      // integrator split for the multiplier
  localparam int unsigned ProdW  = GainW + ErrW;  // multiplier product
  localparam int unsigned AccW   = 82;            // exact sum of one loop
  localparam int unsigned FracSh = 24;            // Q.40 to Q16.16
  localparam int unsigned ShW    = AccW - FracSh; // shifted sum
  localparam int unsigned LimW   = 31;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned StepW  = 4;

  // register indexes
  localparam logic [IdxW-1:0] REG_ALT_KP          = 3'd0;
  localparam logic [IdxW-1:0] REG_ALT_KI_DT       = 3'd1;
  localparam logic [IdxW-1:0] REG_PITCH_KP        = 3'd2;
  localparam logic [IdxW-1:0] REG_PITCH_KI_DT     = 3'd3;
  localparam logic [IdxW-1:0] REG_PITCH_RATE_GAIN = 3'd4;
  localparam logic [IdxW-1:0] REG_PITCH_REF_LIMIT = 3'd5;
  localparam logic [IdxW-1:0] REG_ELEVATOR_HIGH   = 3'd6;
  localparam logic [IdxW-1:0] REG_ELEVATOR_LOW    = 3'd7;

  // register reset values
  localparam logic signed [GainW-1:0] RST_ALT_KP          = 32'sd385876;
  localparam logic signed [GainW-1:0] RST_ALT_KI_DT       = 32'sd335;
  localparam logic signed [GainW-1:0] RST_PITCH_KP        = -32'sd15099494;
  localparam logic signed [GainW-1:0] RST_PITCH_KI_DT     = -32'sd100663;
  localparam logic signed [GainW-1:0] RST_PITCH_RATE_GAIN = -32'sd1342177;
  localparam logic [LimW-1:0]         RST_PITCH_REF_LIMIT = 31'd22876; // 0.349066 rad
  localparam logic signed [SigW-1:0]  RST_ELEVATOR_HIGH   = 32'sd26214;
  localparam logic signed [SigW-1:0]  RST_ELEVATOR_LOW    = -32'sd26214;

  // sequencing condition of a step
  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,  // advance unconditionally
    COND_WAIT_IN  = 2'd1,  // hold until an input transfer
    COND_WAIT_OUT = 2'd2   // hold until the output register is free
  } cond_e;

  // multiplier gain operand
  typedef enum logic [2:0] {
    A_ALT_KP     = 3'd0,
    A_ALT_KI     = 3'd1,
    A_PITCH_KP   = 3'd2,
    A_PITCH_KI   = 3'd3,
    A_RATE_GAIN  = 3'd4
  } asel_e;

  // multiplier signal operand
  typedef enum logic [2:0] {
    B_E_ALT   = 3'd0,
    B_ALT_HI  = 3'd1,
    B_ALT_LO  = 3'd2,
    B_E_P     = 3'd3,
    B_P_HI    = 3'd4,
    B_P_LO    = 3'd5,
    B_RATE    = 3'd6
  } bsel_e;

  // accumulator operation on the registered product
  typedef enum logic [2:0] {
    ACC_NOP    = 3'd0,
    ACC_LOAD   = 3'd1,
    ACC_ADD_HI = 3'd2,  // add product scaled by 2^24
    ACC_ADD    = 3'd3,
    ACC_SUB    = 3'd4
  } accop_e;

  // one microcode word
  typedef struct packed {
    cond_e  cond;
    logic   last;
    asel_e  asel;
    bsel_e  bsel;
    accop_e acc_op;
    logic   int_alt;
    logic   int_pitch;
    logic   lim_ref;
    logic   out_ld;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

  // configuration register file
  typedef struct packed {
    logic signed [GainW-1:0] alt_kp;
    logic signed [GainW-1:0] alt_ki_dt;
    logic signed [GainW-1:0] pitch_kp;
    logic signed [GainW-1:0] pitch_ki_dt;
    logic signed [GainW-1:0] pitch_rate_gain;
    logic [LimW-1:0]         pitch_ref_limit;
    logic signed [SigW-1:0]  elevator_high;
    logic signed [SigW-1:0]  elevator_low;
  } cfg_t;

  localparam logic [StepW-1:0] LAST_STEP = 4'd11;

  // control program, one word per step
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{cond: COND_NEXT, last: 1'b0, asel: A_ALT_KP, bsel: B_E_ALT,
          acc_op: ACC_NOP, int_alt: 1'b0, int_pitch: 1'b0, lim_ref: 1'b0,
          out_ld: 1'b0};
    case (step)
      4'd0: begin
        w.cond = COND_WAIT_IN;
      end
      4'd1: begin
        w.int_alt = 1'b1;
        w.asel    = A_ALT_KP;
        w.bsel    = B_E_ALT;
      end
      4'd2: begin
        w.asel   = A_ALT_KI;
        w.bsel   = B_ALT_HI;
        w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.asel   = A_ALT_KI;
        w.bsel   = B_ALT_LO;
        w.acc_op = ACC_ADD_HI;
      end
      4'd4: begin
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.lim_ref = 1'b1;
      end
      4'd6: begin
        w.int_pitch = 1'b1;
        w.asel      = A_PITCH_KP;
        w.bsel      = B_E_P;
      end
      4'd7: begin
        w.asel   = A_PITCH_KI;
        w.bsel   = B_P_HI;
        w.acc_op = ACC_LOAD;
      end
      4'd8: begin
        w.asel   = A_PITCH_KI;
        w.bsel   = B_P_LO;
        w.acc_op = ACC_ADD_HI;
      end
      4'd9: begin
        w.asel   = A_RATE_GAIN;
        w.bsel   = B_RATE;
        w.acc_op = ACC_ADD;
      end
      4'd10: begin
        w.acc_op = ACC_SUB;
      end
      4'd11: begin
        w.cond   = COND_WAIT_OUT;
        w.out_ld = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/altitude_pitch_cascade_pi_unit.sv]
// ----------------------------------------------------------------------------
// altitude_pitch_cascade_pi_unit
// Cascaded PI altitude/pitch controller with conditional-integration
// anti-windup, run by a microcoded sequencer over one shared multiplier.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   altitude_ref, altitude_meas,
//                                                 pitch_meas, pitch_rate
//   out      source     out_valid_o / out_stall_i elevator_cmd, elevator_clamped,
//                                                 pitch_ref_clamped
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// An item runs through 12 program steps, one control word per cycle while no
// step holds, through a 32x33 multiplier shared by all five gain products; the
// result is loaded at the last step, the output step.
// A new item is taken as soon as the program is back at its first step, while
// the previous result may still wait in the output register.
// The output step holds while the output register is full and stalled.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module altitude_pitch_cascade_pi_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] altitude_ref_i,
  input  logic signed [31:0] altitude_meas_i,
  input  logic signed [31:0] pitch_meas_i,
  input  logic signed [31:0] pitch_rate_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] elevator_cmd_o,
  output logic               elevator_clamped_o,
  output logic               pitch_ref_clamped_o
);
  import apcpi_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt_kp          <= RST_ALT_KP;
      cfg_q.alt_ki_dt       <= RST_ALT_KI_DT;
      cfg_q.pitch_kp        <= RST_PITCH_KP;
      cfg_q.pitch_ki_dt     <= RST_PITCH_KI_DT;
      cfg_q.pitch_rate_gain <= RST_PITCH_RATE_GAIN;
      cfg_q.pitch_ref_limit <= RST_PITCH_REF_LIMIT;
      cfg_q.elevator_high   <= RST_ELEVATOR_HIGH;
      cfg_q.elevator_low    <= RST_ELEVATOR_LOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALT_KP:          cfg_q.alt_kp          <= cfg_wdata_i;
        REG_ALT_KI_DT:       cfg_q.alt_ki_dt       <= cfg_wdata_i;
        REG_PITCH_KP:        cfg_q.pitch_kp        <= cfg_wdata_i;
        REG_PITCH_KI_DT:     cfg_q.pitch_ki_dt     <= cfg_wdata_i;
        REG_PITCH_RATE_GAIN: cfg_q.pitch_rate_gain <= cfg_wdata_i;
        REG_PITCH_REF_LIMIT: cfg_q.pitch_ref_limit <= cfg_wdata_i[LimW-1:0];
        REG_ELEVATOR_HIGH:   cfg_q.elevator_high   <= cfg_wdata_i;
        REG_ELEVATOR_LOW:    cfg_q.elevator_low    <= cfg_wdata_i;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  // input transfer only at the first program step
  assign in_stall_o = (ctrl.cond != COND_WAIT_IN);

  // sequencer
  apcpi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // datapath
  apcpi_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .altitude_ref_i      (altitude_ref_i),
    .altitude_meas_i     (altitude_meas_i),
    .pitch_meas_i        (pitch_meas_i),
    .pitch_rate_i        (pitch_rate_i),
    .out_stall_i         (out_stall_i),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .elevator_cmd_o      (elevator_cmd_o),
    .elevator_clamped_o  (elevator_clamped_o),
    .pitch_ref_clamped_o (pitch_ref_clamped_o)
  );

endmodule

[rtl/core/apcpi_seq.sv]
// ----------------------------------------------------------------------------
// apcpi_seq
// Step counter and control store; one control word per cycle, steps may hold.
// ----------------------------------------------------------------------------
module apcpi_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apcpi_pkg::stat_t  stat_i,
  output apcpi_pkg::ctrl_t  ctrl_o
);
  import apcpi_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ctrl_t            ctrl;
  logic             hold;

  // control word of the current step
  assign ctrl   = ucode(step_q);
  assign ctrl_o = ctrl;

  // conditional hold, wrap after the last step
  always_comb begin
    case (ctrl.cond)
      COND_WAIT_IN:  hold = !stat_i.in_valid;
      COND_WAIT_OUT: hold = !stat_i.out_free;
      default:       hold = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (ctrl.last) begin
      step_d = '0;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // program stays within its steps
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST_STEP)
    else $error("step counter left the program");

  // an input transfer starts the program
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cond == COND_WAIT_IN && stat_i.in_valid) |=> step_q == 4'd1)
    else $error("input transfer did not start the program");

endmodule

[rtl/core/apcpi_dp.sv]
// ----------------------------------------------------------------------------
// apcpi_dp
// Shared multiplier, accumulator, integrators, limiters and result register.
// ----------------------------------------------------------------------------
module apcpi_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  apcpi_pkg::ctrl_t        ctrl_i,
  input  apcpi_pkg::cfg_t         cfg_i,
  input  logic                    in_valid_i,
  input  logic signed [31:0]      altitude_ref_i,
  input  logic signed [31:0]      altitude_meas_i,
  input  logic signed [31:0]      pitch_meas_i,
  input  logic signed [31:0]      pitch_rate_i,
  input  logic                    out_stall_i,
  output apcpi_pkg::stat_t        stat_o,
  output logic                    out_valid_o,
  output logic signed [31:0]      elevator_cmd_o,
  output logic                    elevator_clamped_o,
  output logic                    pitch_ref_clamped_o
);
  import apcpi_pkg::*;

  // saturating integrator add
  function automatic logic signed [IntW-1:0] sat_add(input logic signed [IntW-1:0] acc,
                                                      input logic signed [ErrW-1:0] e);
    logic signed [IntW:0] s;
    s = {acc[IntW-1], acc} + {{(IntW+1-ErrW){e[ErrW-1]}}, e};
    if (s[IntW] != s[IntW-1]) begin
      sat_add = s[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      sat_add = s[IntW-1:0];
    end
  endfunction

  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;

  logic signed [ErrW-1:0]  e_alt_q;
  logic signed [ErrW-1:0]  ep_q, ep_d;
  logic signed [SigW-1:0]  pitch_q, rate_q;
  logic signed [IntW-1:0]  alt_int_q, pitch_int_q;
  logic                    alt_en_q, pitch_en_q;
  logic                    alt_en_d, pitch_en_d;

  logic signed [GainW-1:0] mul_a;
  logic signed [ErrW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ShW-1:0]   sh;

  logic signed [ShW-1:0]   lim_pos, lim_neg, el_hi_b, el_lo_b;
  logic signed [SigW-1:0]  ref_val;
  logic                    ref_hi, ref_lo, el_hi, el_lo;
  logic signed [SigW-1:0]  cmd_d;

  logic                    out_valid_q;
  logic signed [SigW-1:0]  cmd_q;
  logic                    el_clamped_q, ref_clamped_q, ref_clamped_d;
  logic                    ref_clamp_hold_q;

  // handshake status
  assign in_acc   = (ctrl_i.cond == COND_WAIT_IN) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ctrl_i.out_ld && out_free;
  assign stat_o   = '{in_valid: in_valid_i, out_free: out_free};

  // multiplier operand selection
  always_comb begin
    case (ctrl_i.asel)
      A_ALT_KP:    mul_a = cfg_i.alt_kp;
      A_ALT_KI:    mul_a = cfg_i.alt_ki_dt;
      A_PITCH_KP:  mul_a = cfg_i.pitch_kp;
      A_PITCH_KI:  mul_a = cfg_i.pitch_ki_dt;
      A_RATE_GAIN: mul_a = cfg_i.pitch_rate_gain;
      default:     mul_a = '0;
    endcase
    case (ctrl_i.bsel)
      B_E_ALT:  mul_b = e_alt_q;
      B_ALT_HI: mul_b = {{(ErrW-HalfW){alt_int_q[IntW-1]}}, alt_int_q[IntW-1:HalfW]};
      B_ALT_LO: mul_b = {{(ErrW-HalfW){1'b0}}, alt_int_q[HalfW-1:0]};
      B_E_P:    mul_b = ep_q;
      B_P_HI:   mul_b = {{(ErrW-HalfW){pitch_int_q[IntW-1]}}, pitch_int_q[IntW-1:HalfW]};
      B_P_LO:   mul_b = {{(ErrW-HalfW){1'b0}}, pitch_int_q[HalfW-1:0]};
      B_RATE:   mul_b = {rate_q[SigW-1], rate_q};
      default:  mul_b = '0;
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  // accumulate the registered product
  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:   acc_d = prod_ext;
      ACC_ADD_HI: acc_d = acc_q + {prod_ext[AccW-FracSh-1:0], {FracSh{1'b0}}};
      ACC_ADD:    acc_d = acc_q + prod_ext;
      ACC_SUB:    acc_d = acc_q - prod_ext;
      default:    acc_d = acc_q;
    endcase
  end

  // floor of the sum over 2^24
  assign sh = acc_q[AccW-1:FracSh];

  // pitch reference limiter and pitch error
  always_comb begin
    lim_pos = {{(ShW-LimW){1'b0}}, cfg_i.pitch_ref_limit};
    lim_neg = -lim_pos;
    ref_hi  = sh >= lim_pos;
    ref_lo  = sh <= lim_neg;
    if (ref_hi) begin
      ref_val = lim_pos[SigW-1:0];
    end else if (ref_lo) begin
      ref_val = lim_neg[SigW-1:0];
    end else begin
      ref_val = sh[SigW-1:0];
    end
    ref_clamped_d = ref_hi || ref_lo;
    ep_d = {ref_val[SigW-1], ref_val} - {pitch_q[SigW-1], pitch_q};
  end

  // elevator clamp and anti-windup decision
  always_comb begin
    el_hi_b    = {{(ShW-SigW){cfg_i.elevator_high[SigW-1]}}, cfg_i.elevator_high};
    el_lo_b    = {{(ShW-SigW){cfg_i.elevator_low[SigW-1]}}, cfg_i.elevator_low};
    el_hi      = sh >= el_hi_b;
    el_lo      = sh <= el_lo_b;
    cmd_d      = sh[SigW-1:0];
    alt_en_d   = 1'b1;
    pitch_en_d = 1'b1;
    if (el_hi) begin
      cmd_d      = cfg_i.elevator_high;
      pitch_en_d = !ep_q[ErrW-1];
      alt_en_d   = e_alt_q[ErrW-1] || (e_alt_q == '0);
    end else if (el_lo) begin
      cmd_d      = cfg_i.elevator_low;
      pitch_en_d = ep_q[ErrW-1] || (ep_q == '0);
      alt_en_d   = !e_alt_q[ErrW-1];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (in_acc) begin
      e_alt_q <= {altitude_ref_i[SigW-1], altitude_ref_i}
               - {altitude_meas_i[SigW-1], altitude_meas_i};
      pitch_q <= pitch_meas_i;
      rate_q  <= pitch_rate_i;
    end
    // reference flag is held internally until the result register loads
    if (ctrl_i.lim_ref) begin
      ep_q             <= ep_d;
      ref_clamp_hold_q <= ref_clamped_d;
    end
    if (out_load) begin
      cmd_q         <= cmd_d;
      el_clamped_q  <= el_hi || el_lo;
      ref_clamped_q <= ref_clamp_hold_q;
    end
  end

  // integrators, enables and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_int_q   <= '0;
      pitch_int_q <= '0;
      alt_en_q    <= 1'b1;
      pitch_en_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.int_alt && alt_en_q) begin
        alt_int_q <= sat_add(alt_int_q, e_alt_q);
      end
      if (ctrl_i.int_pitch && pitch_en_q) begin
        pitch_int_q <= sat_add(pitch_int_q, ep_q);
      end
      if (out_load) begin
        alt_en_q    <= alt_en_d;
        pitch_en_q  <= pitch_en_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign elevator_cmd_o      = cmd_q;
  assign elevator_clamped_o  = el_clamped_q;
  assign pitch_ref_clamped_o = ref_clamped_q;

  // a result appears only from the output step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.out_ld))
    else $error("result valid without output step");

  // command respects ordered bounds
  a_cmd_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cfg_i.elevator_high >= cfg_i.elevator_low)
      |-> (cmd_q <= cfg_i.elevator_high && cmd_q >= cfg_i.elevator_low))
    else $error("elevator command outside its bounds");

endmodule
